>>> rtl/qcit_pkg.sv
// Shared types and constants for the quorum commit index tracker.
// No dependencies; imported by every module of the block.
package qcit_pkg;

   localparam int MAX_REPLICAS = 8;
   localparam int LOG_W        = 63;
   localparam int SLOT_W       = 3;
   localparam int CSR_W        = 4;
   // scan index covers every replica plus the primary entry
   localparam int IDX_W        = $clog2(MAX_REPLICAS + 1);
   localparam int CNT_W        = $clog2(MAX_REPLICAS + 1);
   localparam int PC_W         = $clog2(MAX_REPLICAS + 2);

   localparam logic FUNC_MATCH = 1'b0;
   localparam logic FUNC_LAST  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] replica_slot;
      logic [LOG_W-1:0]  log_index;
   } req_type;

   typedef struct packed {
      logic [LOG_W-1:0] agreed_index;
      logic [LOG_W-1:0] commit_level;
      logic             commit_advanced;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CAP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             write;
      logic             scan;
      logic [IDX_W-1:0] scan_idx;
      logic             cap;
      logic             finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> rtl/qcit_dp.sv
// Datapath: match table, primary last index, quorum scan, commit index, result word.
// Depends on qcit_pkg; driven by qcit_ctrl through cmd_type / status_type.
module qcit_dp (
   input  logic               clock,
   input  logic               reset,
   input  qcit_pkg::req_type  req_data,
   input  qcit_pkg::cmd_type  cmd,
   output qcit_pkg::status_type status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [qcit_pkg::CSR_W-1:0] csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qcit_pkg::rsp_type  rsp_data
);
   import qcit_pkg::*;

   logic [LOG_W-1:0]  table_ff [MAX_REPLICAS];
   logic [LOG_W-1:0]  primary_ff;
   logic [LOG_W-1:0]  commit_ff;
   logic [CSR_W-1:0]  count_ff;
   logic [LOG_W-1:0]  best_ff;
   logic [LOG_W-1:0]  q_ff;
   logic [LOG_W-1:0]  cand_ff;
   logic              cand_use_ff;
   logic [MAX_REPLICAS:0] ge_ff;
   logic              eval_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [LOG_W-1:0]  vals [MAX_REPLICAS + 1];
   logic [MAX_REPLICAS:0] in_use;
   logic [MAX_REPLICAS:0] ge_in;
   logic [CNT_W-1:0]  n_used;
   logic [PC_W-1:0]   need;
   logic [PC_W-1:0]   pop;
   logic [LOG_W-1:0]  cand;
   logic              out_free;
   logic              advance;

   assign csr_ready = 1'b1;

   always_comb begin
      if (32'(count_ff) > MAX_REPLICAS) begin
         n_used = CNT_W'(MAX_REPLICAS);
      end else begin
         n_used = CNT_W'(count_ff);
      end
      need = PC_W'((32'(n_used) + 1) / 2 + 1);
      for (int j = 0; j < MAX_REPLICAS; j++) begin
         vals[j]   = table_ff[j];
         in_use[j] = (j < 32'(n_used));
      end
      vals[MAX_REPLICAS]   = primary_ff;
      in_use[MAX_REPLICAS] = 1'b1;
      cand = vals[cmd.scan_idx];
      for (int j = 0; j <= MAX_REPLICAS; j++) begin
         ge_in[j] = in_use[j] && (vals[j] >= cand);
      end
   end

   assign pop      = PC_W'($countones(ge_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = q_ff > commit_ff;
   assign status.out_free = out_free;

   // state registers with architectural reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_REPLICAS; j++) begin
            table_ff[j] <= '0;
         end
         primary_ff   <= '0;
         commit_ff    <= '0;
         count_ff     <= '0;
         eval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         if (cmd.write) begin
            if (req_data.func == FUNC_LAST) begin
               primary_ff <= req_data.log_index;
            end else begin
               for (int j = 0; j < MAX_REPLICAS; j++) begin
                  if (32'(req_data.replica_slot) == j) begin
                     table_ff[j] <= req_data.log_index;
                  end
               end
            end
         end
         eval_ff <= cmd.scan;
         if (cmd.finish && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (advance) begin
               commit_ff <= q_ff;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan pipeline and result word
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         ge_ff       <= ge_in;
         cand_ff     <= cand;
         cand_use_ff <= in_use[cmd.scan_idx];
      end
      if (cmd.write) begin
         best_ff <= '0;
      end else if (eval_ff && cand_use_ff && (pop >= need) && (cand_ff > best_ff)) begin
         best_ff <= cand_ff;
      end
      if (cmd.cap) begin
         q_ff <= (best_ff > primary_ff) ? primary_ff : best_ff;
      end
      if (cmd.finish && out_free) begin
         rsp_data_ff.agreed_index    <= q_ff;
         rsp_data_ff.commit_level    <= advance ? q_ff : commit_ff;
         rsp_data_ff.commit_advanced <= advance;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_commit_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> commit_ff >= $past(commit_ff))
      else $error("commit index decreased");

   a_quorum_capped: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> q_ff <= primary_ff)
      else $error("quorum index above last log index");

   a_eval_follows_scan: assert property (@(posedge clock) disable iff (reset)
      eval_ff |-> $past(cmd.scan))
      else $error("evaluation stage active without a scan step");

endmodule

>>> rtl/qcit_ctrl.sv
// Controller FSM: accepts a word, walks the scan index, caps and hands off the result.
// Depends on qcit_pkg; commands qcit_dp.
module qcit_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qcit_pkg::status_type status,
   output qcit_pkg::cmd_type    cmd
);
   import qcit_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] scan_idx_ff;
   logic [IDX_W-1:0] scan_idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      req_stall    = 1'b1;
      cmd.write    = 1'b0;
      cmd.scan     = 1'b0;
      cmd.scan_idx = scan_idx_ff;
      cmd.cap      = 1'b0;
      cmd.finish   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.write   = 1'b1;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            // primary entry sits last in the scan order
            if (scan_idx_ff == IDX_W'(MAX_REPLICAS)) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CAP;
         end
         ST_CAP: begin
            cmd.cap  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            // hold until the result register can take the word
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && $past(state_ff == ST_SCAN)
      |-> scan_idx_ff == $past(scan_idx_ff) + 1'b1)
      else $error("scan index skipped a step");

   a_write_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> (state_ff == ST_SCAN) && (scan_idx_ff == '0))
      else $error("accepted word did not start a scan from entry zero");

endmodule

>>> rtl/quorum_commit_index_tracker.sv
// Quorum commit index tracker: each accepted word writes one replica match index
// (func 0) or the primary last log index (func 1), then returns one result word with
// the quorum index (the (total/2+1)-th largest of the replicas in use plus the primary,
// capped to the last log index), the never-decreasing commit index and an advanced flag.
// The result word is loaded into the output register after a walk of MAX_REPLICAS+1
// scan steps through a single compare row in the datapath, then drain, cap and commit.
// The next word is accepted in the cycle after the result is loaded, even while that
// result is still stalled, and no new word is taken while one is still in the block;
// a result still stalled when the next one is ready holds the block in its commit step.
// replica_count is written through the csr port, always ready; write it only while the
// block is idle.
module quorum_commit_index_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  qcit_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output qcit_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qcit_pkg::CSR_W-1:0]    csr_data
);
   import qcit_pkg::*;

   cmd_type    cmd;
   status_type status;

   qcit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qcit_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/quorum_commit_index_tracker_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for quorum_commit_index_tracker: queue-fed driver, clocked monitor,
// in-bench commit-index predictor. Depends on qcit_pkg and the tracker RTL only.
module quorum_commit_index_tracker_tb;
   import qcit_pkg::*;

   localparam int                QUIET_LIMIT   = 2000;
   localparam int                SETTLE_CYCLES = 4;
   localparam logic [LOG_W-1:0]  LOG_MAX       = '1;

   typedef enum {OP_WORD, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type       kind;
      req_type           word;
      logic [CSR_W-1:0]  setting;
      int unsigned       gap;
   } pending_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_data  = '0;

   quorum_commit_index_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // predictor state
   logic [LOG_W-1:0]  match_mirror [MAX_REPLICAS];
   logic [LOG_W-1:0]  last_mirror   = '0;
   logic [LOG_W-1:0]  commit_mirror = '0;
   logic [CSR_W-1:0]  replica_setting = '0;

   pending_type       pend_q [$];
   rsp_type           commit_expect_q [$];

   int unsigned       mismatches    = 0;
   int unsigned       words_sent    = 0;
   int unsigned       last_writes   = 0;
   int unsigned       results_seen  = 0;
   int unsigned       advances_seen = 0;
   int unsigned       csr_writes    = 0;
   int unsigned       wait_count    = 0;
   int unsigned       hold_left     = 0;
   int unsigned       rsp_calm      = 0;
   int unsigned       send_calm     = 0;
   int unsigned       quiet_cycles  = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic flag_mismatch(string what, logic [LOG_W-1:0] got, logic [LOG_W-1:0] want);
      $display("MISMATCH @%0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // (total/2+1)-th largest of the used replicas plus the primary, capped to last index
   function automatic logic [LOG_W-1:0] quorum_point();
      logic [LOG_W-1:0] pool [MAX_REPLICAS+1];
      logic [LOG_W-1:0] swap;
      int               used;
      int               nodes;
      used = (replica_setting > MAX_REPLICAS) ? MAX_REPLICAS : int'(replica_setting);
      if (used == 0) return last_mirror;
      for (int i = 0; i < used; i++) pool[i] = match_mirror[i];
      pool[used] = last_mirror;
      nodes = used + 1;
      for (int i = 1; i < nodes; i++) begin
         for (int j = i; j > 0 && pool[j-1] < pool[j]; j--) begin
            swap      = pool[j];
            pool[j]   = pool[j-1];
            pool[j-1] = swap;
         end
      end
      swap = pool[nodes/2];
      return (swap > last_mirror) ? last_mirror : swap;
   endfunction

   task automatic predict_commit(req_type w);
      rsp_type r;
      if (w.func == FUNC_MATCH) begin
         match_mirror[w.replica_slot] = w.log_index;
      end else begin
         last_mirror = w.log_index;
         last_writes++;
      end
      r.agreed_index    = quorum_point();
      r.commit_advanced = (r.agreed_index > commit_mirror);
      if (r.commit_advanced) commit_mirror = r.agreed_index;
      r.commit_level    = commit_mirror;
      commit_expect_q.push_back(r);
      words_sent++;
   endtask

   task automatic push_word(logic f, logic [SLOT_W-1:0] s, logic [LOG_W-1:0] v);
      pending_type p;
      p.kind                   = OP_WORD;
      p.word.func              = f;
      p.word.replica_slot      = s;
      p.word.log_index         = v;
      p.setting                = '0;
      if (send_calm > 0) begin
         send_calm--;
         p.gap = 0;
      end else begin
         if ($urandom_range(0, 5) == 0) send_calm = $urandom_range(10, 30);
         p.gap = $urandom_range(0, 11);
      end
      pend_q.push_back(p);
   endtask

   task automatic push_cfg(logic [CSR_W-1:0] v);
      pending_type p;
      p.kind    = OP_CSR;
      p.word    = '0;
      p.setting = v;
      p.gap     = 0;
      pend_q.push_back(p);
   endtask

   // driver: one word or csr write in flight at a time
   always @(posedge clock) begin
      logic              next_valid;
      logic              next_csr_valid;
      req_type           next_word;
      logic [CSR_W-1:0]  next_csr;
      next_valid     = req_valid;
      next_csr_valid = csr_valid;
      next_word      = req_data;
      next_csr       = csr_data;
      if (reset) begin
         next_valid     = 1'b0;
         next_csr_valid = 1'b0;
         wait_count     = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_commit(req_data);
            next_valid = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            replica_setting = csr_data;
            csr_writes++;
            next_csr_valid  = 1'b0;
         end
         if (!next_valid && !next_csr_valid && pend_q.size() != 0) begin
            case (pend_q[0].kind)
               OP_WORD: begin
                  if (wait_count >= pend_q[0].gap) begin
                     next_valid = 1'b1;
                     next_word  = pend_q[0].word;
                     void'(pend_q.pop_front());
                     wait_count = 0;
                  end else begin
                     wait_count++;
                  end
               end
               default: begin
                  // hold until every expected word is back and the block has settled
                  if (commit_expect_q.size() != 0) begin
                     wait_count = 0;
                  end else if (wait_count < SETTLE_CYCLES) begin
                     wait_count++;
                  end else begin
                     if (pend_q[0].kind == OP_CSR) begin
                        next_csr_valid = 1'b1;
                        next_csr       = pend_q[0].setting;
                     end
                     void'(pend_q.pop_front());
                     wait_count = 0;
                  end
               end
            endcase
         end
      end
      req_valid <= next_valid;
      req_data  <= next_word;
      csr_valid <= next_csr_valid;
      csr_data  <= next_csr;
   end

   // monitor: random stall per result word, with calm stretches
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         hold_left = 0;
      end else if (rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_data.commit_advanced) advances_seen++;
         if (commit_expect_q.size() == 0) begin
            flag_mismatch("result word with nothing pending, agreed_index",
                          rsp_data.agreed_index, '0);
         end else begin
            want = commit_expect_q.pop_front();
            if (rsp_data.agreed_index !== want.agreed_index)
               flag_mismatch("agreed_index", rsp_data.agreed_index, want.agreed_index);
            if (rsp_data.commit_level !== want.commit_level)
               flag_mismatch("commit_level", rsp_data.commit_level, want.commit_level);
            if (rsp_data.commit_advanced !== want.commit_advanced)
               flag_mismatch("commit_advanced", LOG_W'(rsp_data.commit_advanced),
                             LOG_W'(want.commit_advanced));
         end
         if (rsp_calm > 0) begin
            rsp_calm--;
            hold_left = 0;
         end else begin
            if ($urandom_range(0, 5) == 0) rsp_calm = $urandom_range(10, 30);
            hold_left = $urandom_range(0, 11);
         end
      end else if (rsp_valid && hold_left > 0) begin
         hold_left--;
      end
      rsp_stall <= (hold_left > 0);
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("quorum_commit_index_tracker verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned       phase_plan [11] = '{1, 2, 3, 5, 8, 4, 0, 6, 7, 9, 15};
      logic [LOG_W-1:0]  head;
      logic [LOG_W-1:0]  v;
      logic [SLOT_W-1:0] slot;
      int unsigned       used;
      int unsigned       pick;
      int unsigned       lag;

      for (int i = 0; i < MAX_REPLICAS; i++) match_mirror[i] = '0;

      // no replicas: quorum follows the last index, commit holds when it drops
      push_word(FUNC_LAST, 3'd0, 63'd3);
      push_word(FUNC_MATCH, 3'd0, LOG_MAX);
      push_word(FUNC_LAST, 3'd7, 63'd2);
      push_word(FUNC_LAST, 3'd0, 63'd4);
      // one replica: quorum is the smaller of the two
      push_cfg(4'd1);
      push_word(FUNC_MATCH, 3'd0, 63'd1);
      push_word(FUNC_MATCH, 3'd0, 63'd6);
      push_word(FUNC_LAST, 3'd5, 63'd8);
      // two replicas; slot 5 is written while out of use
      push_cfg(4'd2);
      push_word(FUNC_MATCH, 3'd1, 63'd9);
      push_word(FUNC_MATCH, 3'd5, 63'd100);
      push_word(FUNC_LAST, 3'd0, 63'd12);
      // count above the table size saturates; slot 5 now takes part
      push_cfg(4'd15);
      push_word(FUNC_MATCH, 3'd2, 63'd11);
      push_word(FUNC_MATCH, 3'd3, 63'd11);
      push_word(FUNC_MATCH, 3'd4, 63'd11);
      push_word(FUNC_MATCH, 3'd7, 63'd12);

      head = 63'd12;
      foreach (phase_plan[ph]) begin
         push_cfg(CSR_W'(phase_plan[ph]));
         used = (phase_plan[ph] > MAX_REPLICAS) ? MAX_REPLICAS : phase_plan[ph];
         for (int k = 0; k < 64; k++) begin
            if (k == 32) begin
               // sender pause until every result word is back
               pend_q.push_back('{kind: OP_DRAIN, word: '0, setting: '0, gap: 0});
            end
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               head = head + LOG_W'($urandom_range(0, 16));
               push_word(FUNC_LAST, SLOT_W'($urandom_range(0, 7)), head);
            end else if (pick < 75) begin
               // replica catching up to a point just behind the head
               if (used > 0 && $urandom_range(0, 3) != 0)
                  slot = SLOT_W'($urandom_range(0, used - 1));
               else
                  slot = SLOT_W'($urandom_range(0, 7));
               lag = $urandom_range(0, 8);
               v   = (head > lag) ? head - LOG_W'(lag) : '0;
               push_word(FUNC_MATCH, slot, v);
            end else if (pick < 88) begin
               push_word(FUNC_MATCH, SLOT_W'($urandom_range(0, 7)),
                         LOG_W'({$urandom, $urandom}));
            end else if (pick < 95) begin
               // lowered last index; the next advance restores it
               lag = $urandom_range(1, 20);
               v   = (head > lag) ? head - LOG_W'(lag) : '0;
               push_word(FUNC_LAST, SLOT_W'($urandom_range(0, 7)), v);
            end else begin
               push_word(FUNC_LAST, SLOT_W'($urandom_range(0, 7)), head);
            end
         end
      end

      // top of the index range, then drop the last index under the commit
      push_cfg(4'd3);
      push_word(FUNC_LAST, 3'd2, LOG_MAX);
      push_word(FUNC_MATCH, 3'd0, LOG_MAX);
      push_word(FUNC_MATCH, 3'd1, LOG_MAX);
      push_word(FUNC_LAST, 3'd0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pend_q.size() != 0 || req_valid || csr_valid || commit_expect_q.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);

      $display("covered %0d words (%0d last-index updates) over %0d replica_count settings,",
               words_sent, last_writes, csr_writes);
      $display("%0d result words checked, %0d commit advances, %0d mismatches",
               results_seen, advances_seen, mismatches);
      if (mismatches == 0) begin
         $display("quorum_commit_index_tracker verification clean");
      end else begin
         $display("quorum_commit_index_tracker verification failed");
      end
      $finish;
   end

endmodule
